// ===== rtl/ycbd_pkg.sv =====
// shared types, constants and table functions of the cell box decode unit
package ycbd_pkg;

    localparam int LOGIT_WIDTH_DEF     = 16;
    localparam int ANCHORS_DEF         = 3;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    // internal logit width, the widest logit the unit accepts
    localparam int LX_W        = 24;
    localparam int SIG_W       = 16;
    localparam int EXP_W       = 29;
    localparam int CNT_W       = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 60;
    localparam int ANCHOR_W    = 10;
    localparam int ANCHOR_PAIR = 20;
    localparam int Q4_W        = 20;
    localparam int POS_W       = 10;
    localparam int CLASS_W     = 8;
    localparam int SUM_W       = 30;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_VARIANT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STRIDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_SIZES   = 3'd4;

    typedef struct packed {
        logic                  decode_variant;
        logic [7:0]            grid_stride;
        logic signed [15:0]    obj_threshold;
        logic [7:0]            class_count;
        logic [CFG_DATA_W-1:0] anchor_sizes;
    } t_cfg;

    typedef struct packed {
        logic signed [LX_W-1:0] tx;
        logic signed [LX_W-1:0] ty;
        logic signed [LX_W-1:0] tw;
        logic signed [LX_W-1:0] th;
        logic signed [LX_W-1:0] obj;
        logic signed [LX_W-1:0] best;
        logic [POS_W-1:0]       col;
        logic [POS_W-1:0]       row;
        logic [1:0]             anchor;
        logic [CLASS_W-1:0]     best_index;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOK0,
        BK_LOOK1,
        BK_LOOK2,
        BK_MUL0,
        BK_MUL1,
        BK_FINISH
    } t_back_state;

    // q16 power of two from a q16 log2 value, cubic on the fraction
    function automatic longint f_exp2_q16(longint u);
        longint n;
        longint f;
        longint p;
        n = u >>> 16;
        f = u - n * 65536;
        p = 65536 + ((f * (45557 + ((f * (14824 + ((f * 5154) >>> 16))) >>> 16))) >>> 16);
        if (n >= 0) begin
            return (n > 30) ? (p <<< 30) : (p <<< n);
        end
        if (n < -40) begin
            return 0;
        end
        return p >>> (-n);
    endfunction

    function automatic longint f_exp_q16(longint x);
        return f_exp2_q16((x * 94548) >>> 8);
    endfunction

    // sigmoid at a q8.8 point, 2^32 / (65536 + e) by shift and subtract
    function automatic longint f_sig_q16(longint m);
        longint den;
        longint rem;
        longint q;
        den = 65536 + f_exp_q16(-m);
        rem = 0;
        q   = 0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem <<< 1) | ((i == 32) ? 64'sd1 : 64'sd0);
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (64'sd1 <<< i);
            end
        end
        return (q > 65535) ? 65535 : q;
    endfunction

    function automatic logic [Q4_W-1:0] f_sat_q4(logic signed [SUM_W-1:0] v);
        if (v < -SUM_W'(524288)) begin
            return Q4_W'(-524288);
        end
        if (v > SUM_W'(524287)) begin
            return Q4_W'(524287);
        end
        return v[Q4_W-1:0];
    endfunction

endpackage

// ===== rtl/ycbd_front.sv =====
// front: takes channel items, keeps box logits and class maximum, issues jobs
module ycbd_front #(
    parameter int LOGIT_WIDTH       = ycbd_pkg::LOGIT_WIDTH_DEF,
    parameter int ANCHORS_PER_LEVEL = ycbd_pkg::ANCHORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [LOGIT_WIDTH-1:0] i_channel_value,
    input  logic [ycbd_pkg::POS_W-1:0]    i_grid_col,
    input  logic [ycbd_pkg::POS_W-1:0]    i_grid_row,
    input  logic [1:0]                    i_anchor_index,
    input  ycbd_pkg::t_cfg                i_cfg,
    input  logic                          i_q_full,
    output logic                          o_push,
    output ycbd_pkg::t_job                o_job
);
    import ycbd_pkg::*;

    logic [CNT_W-1:0]       r_cnt;
    logic signed [LX_W-1:0] r_box [4];
    logic signed [LX_W-1:0] r_obj;
    logic signed [LX_W-1:0] r_best;
    logic [CLASS_W-1:0]     r_best_idx;
    logic [POS_W-1:0]       r_col;
    logic [POS_W-1:0]       r_row;
    logic [1:0]             r_anchor;

    logic signed [LX_W-1:0] x;
    logic signed [LX_W-1:0] thr;
    logic [CNT_W-1:0]       last;
    logic [CLASS_W-1:0]     k;
    logic                   accept;
    logic                   is_end;
    logic                   take_class;
    logic signed [LX_W-1:0] n_best;
    logic [CLASS_W-1:0]     n_best_idx;
    logic [1:0]             anchor_sat;

    assign x       = LX_W'(i_channel_value);
    assign thr     = LX_W'(i_cfg.obj_threshold);
    assign last    = CNT_W'(4) + ((i_cfg.class_count == '0) ? CNT_W'(1)
                                                           : CNT_W'(i_cfg.class_count));
    assign k       = CLASS_W'(r_cnt - CNT_W'(5));
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_end  = (r_cnt >= last);

    // first class seeds the maximum, later ones replace it only when strictly larger
    assign take_class = (r_cnt >= CNT_W'(5)) && ((k == '0) || (x > r_best));
    assign n_best     = take_class ? x : r_best;
    assign n_best_idx = take_class ? k : r_best_idx;

    assign anchor_sat = (i_anchor_index > 2'(ANCHORS_PER_LEVEL - 1))
                      ? 2'(ANCHORS_PER_LEVEL - 1) : i_anchor_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_best_idx <= '0;
        end else if (accept) begin
            r_cnt      <= is_end ? '0 : r_cnt + CNT_W'(1);
            r_best_idx <= n_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_cnt == '0) begin
                r_col    <= i_grid_col;
                r_row    <= i_grid_row;
                r_anchor <= anchor_sat;
            end
            if (r_cnt < CNT_W'(4)) begin
                r_box[r_cnt[1:0]] <= x;
            end
            if (r_cnt == CNT_W'(4)) begin
                r_obj <= x;
            end
            r_best <= n_best;
        end
    end

    assign o_push = accept && is_end && (r_obj >= thr);

    always_comb begin
        o_job.tx         = r_box[0];
        o_job.ty         = r_box[1];
        o_job.tw         = r_box[2];
        o_job.th         = r_box[3];
        o_job.obj        = r_obj;
        o_job.best       = n_best;
        o_job.col        = r_col;
        o_job.row        = r_row;
        o_job.anchor     = r_anchor;
        o_job.best_index = n_best_idx;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(259))
        else $error("channel counter past the longest cell");

    a_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_end) |=> (r_cnt == '0))
        else $error("counter did not restart after the last class");

endmodule

// ===== rtl/ycbd_queue.sv =====
// two-entry job queue between front and back
module ycbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ycbd_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ycbd_pkg::t_job o_job
);
    import ycbd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_Q-1:0] r_count;

    assign o_full  = (r_count == CNT_Q'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] f_next(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_Q'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_Q'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("job queue overrun or underrun");

endmodule

// ===== rtl/ycbd_sig_rom.sv =====
// sigmoid and exp table at bin midpoints, two registered read ports
module ycbd_sig_rom #(
    parameter int ADDR_BITS = ycbd_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic [ADDR_BITS-1:0]                     i_addr_a,
    input  logic [ADDR_BITS-1:0]                     i_addr_b,
    output logic [ycbd_pkg::EXP_W+ycbd_pkg::SIG_W-1:0] o_data_a,
    output logic [ycbd_pkg::EXP_W+ycbd_pkg::SIG_W-1:0] o_data_b
);
    import ycbd_pkg::*;

    localparam int DEPTH   = 1 << ADDR_BITS;
    localparam int STEP    = 1 << (12 - ADDR_BITS);
    localparam int ENTRY_W = EXP_W + SIG_W;

    typedef logic [ENTRY_W-1:0] t_rom [DEPTH];

    // entry holds {exp(mid), sigmoid(mid)}
    function automatic t_rom f_build();
        t_rom   tab;
        longint mid;
        for (int i = 0; i < DEPTH; i++) begin
            mid    = longint'(i) * STEP + STEP / 2 - 2048;
            tab[i] = {EXP_W'(f_exp_q16(mid)), SIG_W'(f_sig_q16(mid))};
        end
        return tab;
    endfunction

    localparam t_rom ROM = f_build();

    always_ff @(posedge i_clk) begin
        o_data_a <= ROM[i_addr_a];
        o_data_b <= ROM[i_addr_b];
    end

endmodule

// ===== rtl/ycbd_back.sv =====
// back: sequencer that turns one job into corners and score
module ycbd_back #(
    parameter int TABLE_ADDR_BITS = ycbd_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ycbd_pkg::t_cfg              i_cfg,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  ycbd_pkg::t_job              i_job,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [ycbd_pkg::Q4_W-1:0] o_box_x1,
    output logic signed [ycbd_pkg::Q4_W-1:0] o_box_y1,
    output logic signed [ycbd_pkg::Q4_W-1:0] o_box_x2,
    output logic signed [ycbd_pkg::Q4_W-1:0] o_box_y2,
    output logic [ycbd_pkg::SIG_W-1:0]  o_score,
    output logic [ycbd_pkg::CLASS_W-1:0] o_best_class
);
    import ycbd_pkg::*;

    localparam int AB      = TABLE_ADDR_BITS;
    localparam int ENTRY_W = EXP_W + SIG_W;
    localparam int D_W     = SIG_W + 1;
    localparam int CP_W    = 37;
    localparam int WP_W    = 44;
    localparam int W_W     = 27;
    localparam int C_W     = CP_W - 12;

    t_back_state r_state;
    t_back_state n_state;

    t_job                   r_job;
    logic [SIG_W-1:0]       r_sx;
    logic [SIG_W-1:0]       r_sy;
    logic [EXP_W-1:0]       r_ew;
    logic [EXP_W-1:0]       r_eh;
    logic [D_W-1:0]         r_dw;
    logic [D_W-1:0]         r_dh;
    logic [2*SIG_W-1:0]     r_score_p;
    logic signed [CP_W-1:0] r_cxp;
    logic signed [CP_W-1:0] r_cyp;
    logic [WP_W-1:0]        r_wp;
    logic [WP_W-1:0]        r_hp;
    logic                   r_out_valid;

    logic [AB-1:0]          addr_a;
    logic [AB-1:0]          addr_b;
    logic [ENTRY_W-1:0]     rom_a;
    logic [ENTRY_W-1:0]     rom_b;
    logic [ANCHOR_W-1:0]    aw;
    logic [ANCHOR_W-1:0]    ah;
    logic signed [8:0]      stride_s;
    logic signed [27:0]     cin_x;
    logic signed [27:0]     cin_y;
    logic [W_W-1:0]         w_x;
    logic [W_W-1:0]         w_y;
    logic signed [SUM_W-1:0] a_x;
    logic signed [SUM_W-1:0] a_y;
    logic signed [SUM_W-1:0] b_x;
    logic signed [SUM_W-1:0] b_y;
    logic                   load_out;

    function automatic logic [AB-1:0] f_addr(logic signed [LX_W-1:0] x);
        logic signed [LX_W-1:0] c;
        logic [LX_W-1:0]        u;
        if (x < -LX_W'(2048)) begin
            c = -LX_W'(2048);
        end else if (x > LX_W'(2047)) begin
            c = LX_W'(2047);
        end else begin
            c = x;
        end
        u = c + LX_W'(2048);
        return u[11 -: AB];
    endfunction

    ycbd_sig_rom #(.ADDR_BITS(AB)) u_rom (
        .i_clk   (i_clk),
        .i_addr_a(addr_a),
        .i_addr_b(addr_b),
        .o_data_a(rom_a),
        .o_data_b(rom_b)
    );

    assign aw = i_cfg.anchor_sizes[ANCHOR_PAIR*r_job.anchor +: ANCHOR_W];
    assign ah = i_cfg.anchor_sizes[ANCHOR_PAIR*r_job.anchor + ANCHOR_W +: ANCHOR_W];
    assign stride_s = $signed({1'b0, i_cfg.grid_stride});

    // centre term before stride: sigmoid plus cell, or 2*sigmoid - 0.5 plus cell
    always_comb begin
        if (!i_cfg.decode_variant) begin
            cin_x = $signed({2'b00, r_job.col, r_sx});
            cin_y = $signed({2'b00, r_job.row, r_sy});
        end else begin
            cin_x = $signed({2'b00, r_job.col, 16'd0}) + $signed({11'd0, r_sx, 1'b0})
                  - 28'sd32768;
            cin_y = $signed({2'b00, r_job.row, 16'd0}) + $signed({11'd0, r_sy, 1'b0})
                  - 28'sd32768;
        end
    end

    always_comb begin
        w_x = i_cfg.decode_variant ? W_W'(r_wp[WP_W-1:28]) : r_wp[38:12];
        w_y = i_cfg.decode_variant ? W_W'(r_hp[WP_W-1:28]) : r_hp[38:12];
        a_x = SUM_W'($signed(r_cxp[CP_W-1:12])) - $signed({4'd0, w_x[W_W-1:1]});
        a_y = SUM_W'($signed(r_cyp[CP_W-1:12])) - $signed({4'd0, w_y[W_W-1:1]});
        b_x = a_x + $signed({3'd0, w_x});
        b_y = a_y + $signed({3'd0, w_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        addr_a   = '0;
        addr_b   = '0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_LOOK0;
                end
            end
            BK_LOOK0: begin
                addr_a  = f_addr(r_job.tx);
                addr_b  = f_addr(r_job.ty);
                n_state = BK_LOOK1;
            end
            BK_LOOK1: begin
                addr_a  = f_addr(r_job.tw);
                addr_b  = f_addr(r_job.th);
                n_state = BK_LOOK2;
            end
            BK_LOOK2: begin
                addr_a  = f_addr(r_job.best);
                addr_b  = f_addr(r_job.obj);
                n_state = BK_MUL0;
            end
            BK_MUL0: begin
                n_state = BK_MUL1;
            end
            BK_MUL1: begin
                n_state = BK_FINISH;
            end
            BK_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            BK_LOOK1: begin
                r_sx <= rom_a[SIG_W-1:0];
                r_sy <= rom_b[SIG_W-1:0];
            end
            BK_LOOK2: begin
                r_ew <= rom_a[ENTRY_W-1:SIG_W];
                r_eh <= rom_b[ENTRY_W-1:SIG_W];
                r_dw <= {rom_a[SIG_W-1:0], 1'b0};
                r_dh <= {rom_b[SIG_W-1:0], 1'b0};
            end
            BK_MUL0: begin
                r_score_p <= (2*SIG_W)'(rom_a[SIG_W-1:0]) * (2*SIG_W)'(rom_b[SIG_W-1:0]);
                r_cxp     <= CP_W'(cin_x) * CP_W'(stride_s);
                r_cyp     <= CP_W'(cin_y) * CP_W'(stride_s);
                if (!i_cfg.decode_variant) begin
                    r_wp <= WP_W'(r_ew * aw);
                    r_hp <= WP_W'(r_eh * ah);
                end else begin
                    r_wp <= WP_W'(r_dw * r_dw);
                    r_hp <= WP_W'(r_dh * r_dh);
                end
            end
            BK_MUL1: begin
                if (i_cfg.decode_variant) begin
                    r_wp <= WP_W'(r_wp[2*D_W-1:0] * aw);
                    r_hp <= WP_W'(r_hp[2*D_W-1:0] * ah);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_box_x1     <= f_sat_q4(a_x);
            o_box_y1     <= f_sat_q4(a_y);
            o_box_x2     <= f_sat_q4(b_x);
            o_box_y2     <= f_sat_q4(b_y);
            o_score      <= r_score_p[2*SIG_W-1:SIG_W];
            o_best_class <= r_job.best_index;
        end
    end

    assign o_valid = r_out_valid;

    a_finish_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FINISH && r_out_valid && !i_ready) |=> (r_state == BK_FINISH))
        else $error("result overwritten while the previous one waits");

endmodule

// ===== rtl/yolo_cell_box_decode_unit.sv =====
// top level of the grid cell box decode unit: config registers, front, queue, back
//
//  channel  valid / ready              payload
//  input    i_valid / o_ready          i_channel_value, i_grid_col, i_grid_row, i_anchor_index
//  output   o_valid / i_ready          o_box_x1, o_box_y1, o_box_x2, o_box_y2, o_score,
//                                      o_best_class
//  config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  the front takes one channel item per cycle unless the queue is full; a cell of n classes
//  takes n + 5 items; the back serves one detection at a time: pop, three table reads, two
//  multiply steps, finish (held while the previous result waits), set by the shared two-port
//  sigmoid table and the multiply sequence; the two-entry job queue stalls the front only
//  when two detections are pending; reset is synchronous and there is no clearing pass
//  config is always ready and takes effect on the next cycle
module yolo_cell_box_decode_unit #(
    parameter int LOGIT_WIDTH       = ycbd_pkg::LOGIT_WIDTH_DEF,
    parameter int ANCHORS_PER_LEVEL = ycbd_pkg::ANCHORS_DEF,
    parameter int TABLE_ADDR_BITS   = ycbd_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [LOGIT_WIDTH-1:0]     i_channel_value,
    input  logic [ycbd_pkg::POS_W-1:0]        i_grid_col,
    input  logic [ycbd_pkg::POS_W-1:0]        i_grid_row,
    input  logic [1:0]                        i_anchor_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [ycbd_pkg::Q4_W-1:0]  o_box_x1,
    output logic signed [ycbd_pkg::Q4_W-1:0]  o_box_y1,
    output logic signed [ycbd_pkg::Q4_W-1:0]  o_box_x2,
    output logic signed [ycbd_pkg::Q4_W-1:0]  o_box_y2,
    output logic [ycbd_pkg::SIG_W-1:0]        o_score,
    output logic [ycbd_pkg::CLASS_W-1:0]      o_best_class,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ycbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ycbd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ycbd_pkg::*;

    t_cfg r_cfg;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decode_variant <= 1'b0;
            r_cfg.grid_stride    <= 8'd8;
            r_cfg.obj_threshold  <= -16'sd1005;
            r_cfg.class_count    <= 8'd80;
            r_cfg.anchor_sizes   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DECODE_VARIANT: r_cfg.decode_variant <= i_cfg_data[0];
                CFG_GRID_STRIDE:    r_cfg.grid_stride    <= i_cfg_data[7:0];
                CFG_OBJ_THRESHOLD:  r_cfg.obj_threshold  <= i_cfg_data[15:0];
                CFG_CLASS_COUNT:    r_cfg.class_count    <= i_cfg_data[7:0];
                CFG_ANCHOR_SIZES:   r_cfg.anchor_sizes   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ycbd_front #(
        .LOGIT_WIDTH      (LOGIT_WIDTH),
        .ANCHORS_PER_LEVEL(ANCHORS_PER_LEVEL)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_channel_value(i_channel_value),
        .i_grid_col     (i_grid_col),
        .i_grid_row     (i_grid_row),
        .i_anchor_index (i_anchor_index),
        .i_cfg          (r_cfg),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (job_in)
    );

    ycbd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (job_in),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_job  (job_out)
    );

    ycbd_back #(
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_job       (job_out),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_box_x1    (o_box_x1),
        .o_box_y1    (o_box_y1),
        .o_box_x2    (o_box_x2),
        .o_box_y2    (o_box_y2),
        .o_score     (o_score),
        .o_best_class(o_best_class)
    );

endmodule
